// ===== rtl/mcr_pkg.sv =====
package mcr_pkg;

	typedef enum logic {
		OP_START = 1'b0,
		OP_STEP  = 1'b1
	} op_t;

	localparam int COLOR_BITS = 4;
	localparam int WIDTH_BITS = 8;

	// midpoint decision constants
	localparam int DEC_INIT      = 3;
	localparam int DEC_STEP_DIAG = 10;
	localparam int DEC_STEP_AXIS = 6;

	localparam int PIX_PER_STEP = 8;
	localparam int PIX_CNT_BITS = $clog2(PIX_PER_STEP);

	typedef logic [PIX_CNT_BITS-1:0] pix_cnt_t;

endpackage

// ===== rtl/midpoint_circle_rasterizer_top.sv =====
// path: a step beat fills the pixel buffer, which loads its first pixel into the output register
// output: eight pixels per step beat, one per cycle unless out_stall holds them
// the next step beat is taken as the last pixel loads; a start beat emits nothing
// and waits only while pixels still drain from the pixel buffer
// reset: asynchronous, active low; clears busy, buffer valid and count, and the output valid
module midpoint_circle_rasterizer_top #(
	parameter int COORD_BITS  = 12,
	parameter int RADIUS_BITS = 10
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic                                  op,
	input  logic signed [COORD_BITS-1:0]          center_x,
	input  logic signed [COORD_BITS-1:0]          center_y,
	input  logic        [RADIUS_BITS-1:0]         inner_radius,
	input  logic        [RADIUS_BITS-1:0]         outer_radius,
	input  logic        [mcr_pkg::COLOR_BITS-1:0] color,
	input  logic        [mcr_pkg::WIDTH_BITS-1:0] pen_width,
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic signed [COORD_BITS:0]            pixel_x,
	output logic signed [COORD_BITS:0]            pixel_y,
	output logic        [mcr_pkg::COLOR_BITS-1:0] pixel_color,
	output logic        [mcr_pkg::WIDTH_BITS-1:0] pixel_width,
	output logic                                  last
);
	import mcr_pkg::*;

	localparam int RN = RADIUS_BITS + 1;       // radius counter, may pass the outer radius
	localparam int OW = RADIUS_BITS + 2;       // signed offsets, y may dip to -1
	localparam int DW = RADIUS_BITS + 4;       // signed decision value
	localparam int SW = COORD_BITS + OW + 1;   // wide sum before wrapping

	// drawing state
	logic                         busy_q;
	logic signed [OW-1:0]         offset_x_q, offset_y_q;
	logic signed [DW-1:0]         decision_q;
	logic        [RN-1:0]         radius_now_q;
	logic        [RADIUS_BITS-1:0] radius_end_q;
	logic signed [COORD_BITS-1:0] centre_x_q, centre_y_q;
	logic        [COLOR_BITS-1:0] color_q;
	logic        [WIDTH_BITS-1:0] width_q;

	// pixel buffer for the step being emitted
	logic                         pend_v_q;
	pix_cnt_t                     pend_cnt_q;
	logic signed [OW-1:0]         pend_x_q, pend_y_q;
	logic signed [COORD_BITS-1:0] pend_cx_q, pend_cy_q;
	logic        [COLOR_BITS-1:0] pend_color_q;
	logic        [WIDTH_BITS-1:0] pend_width_q;
	logic                         pend_fin_q;

	// output register
	logic                         out_v_q;
	logic signed [COORD_BITS:0]   out_x_q, out_y_q;
	logic        [COLOR_BITS-1:0] out_color_q;
	logic        [WIDTH_BITS-1:0] out_width_q;
	logic                         out_last_q;

	logic in_accept, out_load, pend_done, step_emit;

	assign out_load  = pend_v_q && (!out_v_q || !out_stall);
	assign pend_done = out_load && (pend_cnt_q == pix_cnt_t'(PIX_PER_STEP - 1));
	assign in_stall  = pend_v_q && !pend_done;
	assign in_accept = in_valid && !in_stall;
	assign step_emit = in_accept && (op_t'(op) == OP_STEP) && busy_q;

	// one midpoint iteration
	logic signed [DW-1:0] x_ext, y_ext, dec_next;
	logic signed [OW-1:0] x_next, y_next;
	logic        [RN-1:0] r_next;
	logic                 ring_done, draw_done;
	logic signed [DW-1:0] dec_init_next, dec_init_start;
	logic        [RN-1:0] r_start;

	always_comb begin
		x_ext  = DW'(offset_x_q);
		y_ext  = DW'(offset_y_q);
		x_next = offset_x_q + OW'(1);
		if (decision_q > 0) begin
			dec_next = decision_q + ((x_ext - y_ext) <<< 2) + DW'(DEC_STEP_DIAG);
			y_next   = offset_y_q - OW'(1);
		end else begin
			dec_next = decision_q + (x_ext <<< 2) + DW'(DEC_STEP_AXIS);
			y_next   = offset_y_q;
		end
		ring_done     = x_next > y_next;
		r_next        = radius_now_q + RN'(1);
		draw_done     = ring_done && (r_next > {1'b0, radius_end_q});
		dec_init_next = DW'(DEC_INIT) - (DW'(r_next) <<< 1);
		r_start       = {1'b0, inner_radius};
		dec_init_start = DW'(DEC_INIT) - (DW'(r_start) <<< 1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q       <= 1'b0;
			offset_x_q   <= '0;
			offset_y_q   <= '0;
			decision_q   <= '0;
			radius_now_q <= '0;
			radius_end_q <= '0;
			centre_x_q   <= '0;
			centre_y_q   <= '0;
			color_q      <= '0;
			width_q      <= '0;
		end else if (in_accept) begin
			if (op_t'(op) == OP_START) begin
				centre_x_q   <= center_x;
				centre_y_q   <= center_y;
				color_q      <= color;
				width_q      <= pen_width;
				radius_now_q <= r_start;
				radius_end_q <= outer_radius;
				offset_x_q   <= '0;
				offset_y_q   <= OW'(r_start);
				decision_q   <= dec_init_start;
				busy_q       <= inner_radius <= outer_radius;
			end else if (busy_q) begin
				if (ring_done) begin
					radius_now_q <= r_next;
					if (draw_done) begin
						busy_q     <= 1'b0;
						offset_x_q <= x_next;
						offset_y_q <= y_next;
						decision_q <= dec_next;
					end else begin
						offset_x_q <= '0;
						offset_y_q <= OW'(r_next);
						decision_q <= dec_init_next;
					end
				end else begin
					offset_x_q <= x_next;
					offset_y_q <= y_next;
					decision_q <= dec_next;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_v_q   <= 1'b0;
			pend_cnt_q <= '0;
		end else if (step_emit) begin
			pend_v_q   <= 1'b1;
			pend_cnt_q <= '0;
		end else if (pend_done) begin
			pend_v_q   <= 1'b0;
		end else if (out_load) begin
			pend_cnt_q <= pend_cnt_q + pix_cnt_t'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (step_emit) begin
			pend_x_q     <= offset_x_q;
			pend_y_q     <= offset_y_q;
			pend_cx_q    <= centre_x_q;
			pend_cy_q    <= centre_y_q;
			pend_color_q <= color_q;
			pend_width_q <= width_q;
			pend_fin_q   <= draw_done;
		end
	end

	// symmetric pixel select: bit 2 swaps x and y, bit 0 negates dx, bit 1 negates dy
	logic signed [OW-1:0] dx, dy;
	logic signed [SW-1:0] px_sum, py_sum;

	always_comb begin
		dx = pend_cnt_q[2] ? pend_y_q : pend_x_q;
		dy = pend_cnt_q[2] ? pend_x_q : pend_y_q;
		if (pend_cnt_q[0]) dx = -dx;
		if (pend_cnt_q[1]) dy = -dy;
		px_sum = SW'(pend_cx_q) + SW'(dx);
		py_sum = SW'(pend_cy_q) + SW'(dy);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (out_load) begin
			out_v_q <= 1'b1;
		end else if (!out_stall) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_x_q     <= px_sum[COORD_BITS:0];
			out_y_q     <= py_sum[COORD_BITS:0];
			out_color_q <= pend_color_q;
			out_width_q <= pend_width_q;
			out_last_q  <= pend_fin_q && (pend_cnt_q == pix_cnt_t'(PIX_PER_STEP - 1));
		end
	end

	assign out_valid   = out_v_q;
	assign pixel_x     = out_x_q;
	assign pixel_y     = out_y_q;
	assign pixel_color = out_color_q;
	assign pixel_width = out_width_q;
	assign last        = out_last_q;

endmodule
